// ===== sv/twps_pkg.sv =====
`timescale 1ns / 1ps

package twps_pkg;

   // Task count limits and field widths
   localparam int unsigned DEF_NUM_TASKS = 5;
   localparam int unsigned TASK_W        = 3;
   localparam int unsigned PRIO_W        = 5;
   localparam int unsigned RANK_W        = 6;
   localparam int unsigned TICK_W        = 32;
   localparam int unsigned CMD_W         = 2;
   localparam int unsigned CSR_IDX_W     = 3;

   // Stream payload widths
   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 8;

   // Item commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELAY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_KILL  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SCHED = 2'd3;

   // Task status codes
   localparam logic [1:0] ST_KILLED    = 2'd0;
   localparam logic [1:0] ST_SUSPENDED = 2'd1;
   localparam logic [1:0] ST_DELAYED   = 2'd2;
   localparam logic [1:0] ST_READY     = 2'd3;

   // Lowest rank a ready task must reach to be picked
   localparam logic [RANK_W-1:0] RANK_FLOOR = 6'd2;

   // Operations broadcast to the cells
   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_TICK    = 3'd1;
   localparam logic [2:0] OP_DELAY   = 3'd2;
   localparam logic [2:0] OP_SUSPEND = 3'd3;
   localparam logic [2:0] OP_KILL    = 3'd4;

   // Best-so-far candidate handed from cell to cell during a scan
   typedef struct packed {
      logic              valid;
      logic [RANK_W-1:0] rank;
      logic [TASK_W-1:0] pick;
   } token_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic [2:0]        op;
      logic [TASK_W-1:0] target;
      logic              inject;
      logic              flush;
      logic [TICK_W-1:0] now_tick;
      logic [TICK_W-1:0] wake_val;
   } cell_ctrl_type;

endpackage

// ===== sv/twps_cell.sv =====
`timescale 1ns / 1ps

module twps_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  twps_pkg::cell_ctrl_type       ctrl,
   input  logic                          csr_we,
   input  logic [twps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [twps_pkg::PRIO_W-1:0]   csr_wdata,
   input  twps_pkg::token_type           tok_left,
   output twps_pkg::token_type           tok_out,
   output logic                          wake_hit
);
   import twps_pkg::*;

   localparam logic [TASK_W-1:0]    MY_IDX   = TASK_W'(IDX);
   localparam logic [CSR_IDX_W-1:0] MY_CSR   = CSR_IDX_W'(IDX);
   localparam logic [PRIO_W-1:0]    PRIO_RST = (IDX == 0) ? '0 : PRIO_W'(1);

   logic [1:0]        status_ff, status_in;
   logic [TICK_W-1:0] wake_ff, wake_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   token_type         tok_ff, tok_in, tok_src, tok_inject;
   logic [RANK_W-1:0] rank;
   logic              targeted;

   assign targeted = (ctrl.target == MY_IDX);
   assign wake_hit = (wake_ff == ctrl.now_tick);
   assign rank     = {1'b0, prio_ff} + RANK_FLOOR;

   // Decode the broadcast operation into status and wake tick updates
   always_comb begin
      status_in = status_ff;
      wake_in   = wake_ff;
      unique case (ctrl.op)
         OP_NONE: begin
         end
         OP_TICK: begin
            if (wake_hit) status_in = ST_READY;
         end
         OP_DELAY: begin
            if (targeted) begin
               wake_in   = ctrl.wake_val;
               status_in = ST_DELAYED;
            end
         end
         OP_SUSPEND: begin
            if (targeted) status_in = ST_SUSPENDED;
         end
         OP_KILL: begin
            if (targeted) status_in = ST_KILLED;
         end
         default: begin
         end
      endcase
   end

   // Take a priority write addressed to this task
   assign prio_in = (csr_we && csr_index == MY_CSR) ? csr_wdata : prio_ff;

   // Start a scan here or take the neighbor's candidate; replace it when this
   // task is ready and ranks at least as high
   always_comb begin
      tok_inject.valid = 1'b1;
      tok_inject.rank  = RANK_FLOOR;
      tok_inject.pick  = '0;
      tok_src = (ctrl.inject && targeted) ? tok_inject : tok_left;
      tok_in  = tok_src;
      if (tok_src.valid && status_ff == ST_READY && rank >= tok_src.rank) begin
         tok_in.rank = rank;
         tok_in.pick = MY_IDX;
      end
      tok_in.valid = tok_src.valid && !ctrl.flush;
   end

   always_ff @(posedge clock) begin
      // Candidate payload needs no reset
      tok_ff.rank <= tok_in.rank;
      tok_ff.pick <= tok_in.pick;
      if (reset) begin
         status_ff    <= ST_READY;
         wake_ff      <= '1;
         prio_ff      <= PRIO_RST;
         tok_ff.valid <= 1'b0;
      end else begin
         status_ff    <= status_in;
         wake_ff      <= wake_in;
         prio_ff      <= prio_in;
         tok_ff.valid <= tok_in.valid;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== sv/task_wake_and_priority_select.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Transfer when            Payload
// req_     in         req_tvalid & req_tready   tuser: cmd[1:0]
//                                               tdata: now_tick[31:0], delay_ticks[63:32]
// rsp_     out        rsp_tvalid & rsp_tready   tdata: current_task[2:0], yield_flag[3]
// csr_     in         csr_we                    csr_index selects prio_task0..4
//
// Tick, delay and kill items pass through the execute and result states; a
// schedule item passes through the scan, done and result states, since the best-candidate token walks the ring of
// task cells one cell per cycle. One item is in work at a time; the result
// register lets the next item transfer in while a result waits.
// Reset is synchronous and active high: all tasks ready, wake ticks all ones.
// A stalled result holds the sequencer in its result state until taken.
module task_wake_and_priority_select #(
   parameter int unsigned NUM_TASKS = twps_pkg::DEF_NUM_TASKS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [twps_pkg::REQ_TDATA_W-1:0] req_tdata,  // now_tick, delay_ticks
   input  logic [twps_pkg::REQ_TUSER_W-1:0] req_tuser,  // cmd
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [twps_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // current_task, yield_flag
   input  logic                             csr_we,
   input  logic [twps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twps_pkg::PRIO_W-1:0]      csr_wdata
);
   import twps_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DONE   = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   localparam logic [TASK_W-1:0] LAST_CELL = TASK_W'(NUM_TASKS - 1);

   logic [2:0]        state_ff, state_in;
   logic [TASK_W-1:0] cnt_ff, cnt_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [TICK_W-1:0] now_ff, now_in;
   logic [TICK_W-1:0] dly_ff, dly_in;
   logic [TASK_W-1:0] running_ff, running_in;
   logic              pending_ff, pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TASK_W-1:0] rsp_task_ff, rsp_task_in;
   logic              rsp_yield_ff, rsp_yield_in;

   cell_ctrl_type         ctrl;
   token_type             tok [NUM_TASKS];
   logic [NUM_TASKS-1:0]  hit;
   logic [NUM_TASKS-1:0]  tok_valid;
   logic [TASK_W-1:0]     pick_or;
   logic                  req_xfer;
   logic                  rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_tready);

   // Ring of task cells; each takes its candidate from the previous cell
   for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
      twps_cell #(.IDX(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .csr_we    (csr_we),
         .csr_index (csr_index),
         .csr_wdata (csr_wdata),
         .tok_left  (tok[(g + NUM_TASKS - 1) % NUM_TASKS]),
         .tok_out   (tok[g]),
         .wake_hit  (hit[g])
      );
      assign tok_valid[g] = tok[g].valid;
   end

   // Collect the pick from whichever cell holds the finished candidate
   always_comb begin
      pick_or = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (tok[i].valid) pick_or = pick_or | tok[i].pick;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      dly_in        = dly_ff;
      running_in    = running_ff;
      pending_in    = pending_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_yield_in  = rsp_yield_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ctrl.op       = OP_NONE;
      ctrl.target   = running_ff;
      ctrl.inject   = 1'b0;
      ctrl.flush    = 1'b0;
      ctrl.now_tick = now_ff;
      ctrl.wake_val = now_ff + dly_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in   = req_tuser;
               now_in   = req_tdata[TICK_W-1:0];
               dly_in   = req_tdata[2*TICK_W-1:TICK_W];
               cnt_in   = '0;
               state_in = (req_tuser == CMD_SCHED) ? S_SCAN : S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff)
               CMD_TICK: begin
                  ctrl.op = OP_TICK;
                  if (|hit) pending_in = 1'b1;
               end
               CMD_DELAY: ctrl.op = (dly_ff == '1) ? OP_SUSPEND : OP_DELAY;
               CMD_KILL:  ctrl.op = OP_KILL;
               default:   ctrl.op = OP_NONE;
            endcase
            state_in = S_RESULT;
         end
         S_SCAN: begin
            ctrl.inject = (cnt_ff == '0);
            cnt_in      = cnt_ff + TASK_W'(1);
            if (cnt_ff == LAST_CELL) state_in = S_DONE;
         end
         S_DONE: begin
            ctrl.flush = 1'b1;
            running_in = pick_or;
            pending_in = (pick_or != running_ff);
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_load) begin
               rsp_task_in  = running_ff;
               rsp_yield_in = pending_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      cmd_ff       <= cmd_in;
      now_ff       <= now_in;
      dly_ff       <= dly_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_yield_ff <= rsp_yield_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - TASK_W - 1){1'b0}}, rsp_yield_ff, rsp_task_ff};

   // Checks
   a_running_range: assert property (@(posedge clock) disable iff (reset)
      running_ff < TASK_W'(NUM_TASKS))
      else $error("running task out of range");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (tok_valid == '0))
      else $error("scan token left in ring while idle");

   a_done_one_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> $onehot(tok_valid))
      else $error("scan did not end with exactly one candidate");

   a_load_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_tvalid && req_tready))
      else $error("result load did not free the sequencer");

endmodule

// ===== bench/twps_sched_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels and the register port of the scheduler,
// keeps a shadow of the task table and compares every result transfer
// against the oldest predicted decision.
module twps_sched_checker #(
   parameter int unsigned NUM_TASKS = twps_pkg::DEF_NUM_TASKS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [twps_pkg::REQ_TDATA_W-1:0] req_tdata,  // now_tick, delay_ticks
   input  logic [twps_pkg::REQ_TUSER_W-1:0] req_tuser,  // cmd
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [twps_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // current_task, yield_flag
   input  logic                             csr_we,
   input  logic [twps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twps_pkg::PRIO_W-1:0]      csr_wdata,
   output int unsigned                      mismatches,
   output int unsigned                      outstanding
);
   import twps_pkg::*;

   localparam logic [TICK_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [TASK_W-1:0] run_task;
      logic              yield_req;
   } decision_type;

   // Shadow of the scheduler state
   logic [PRIO_W-1:0] prio_q   [DEF_NUM_TASKS];
   logic [1:0]        status_q [DEF_NUM_TASKS];
   logic [TICK_W-1:0] wake_q   [DEF_NUM_TASKS];
   logic [TASK_W-1:0] running_q;
   logic              yield_q;

   decision_type due_decisions[$];
   int unsigned  fail_tally;

   // Apply one command to the shadow and return the decision it leaves behind
   function automatic decision_type advance_sched(input logic [CMD_W-1:0] cmd,
                                                  input logic [TICK_W-1:0] now_tick,
                                                  input logic [TICK_W-1:0] dly);
      int unsigned       i;
      int unsigned       pos;
      int unsigned       start;
      logic [RANK_W-1:0] best;
      logic [RANK_W-1:0] rank;
      logic [TASK_W-1:0] pick;
      logic [TASK_W-1:0] cur;
      decision_type      d;
      cur = TASK_W'(32'(running_q) % NUM_TASKS);
      case (cmd)
         CMD_TICK: begin
            // a matching wake tick revives the task whatever its status
            for (i = 0; i < NUM_TASKS; i++) begin
               if (wake_q[i] == now_tick) begin
                  status_q[i] = ST_READY;
                  yield_q     = 1'b1;
               end
            end
         end
         CMD_DELAY: begin
            // all ones suspends and keeps the old wake tick
            if (dly == ALL_ONES) begin
               status_q[cur] = ST_SUSPENDED;
            end else begin
               wake_q[cur]   = now_tick + dly;
               status_q[cur] = ST_DELAYED;
            end
         end
         CMD_KILL: begin
            status_q[cur] = ST_KILLED;
         end
         default: begin
            // cyclic scan from the running task, ties go to the last one met
            start = 32'(cur);
            pos   = start;
            best  = RANK_FLOOR;
            pick  = '0;
            for (i = 0; i < NUM_TASKS; i++) begin
               if (status_q[pos] == ST_READY) begin
                  rank = {1'b0, prio_q[pos]} + RANK_FLOOR;
                  if (rank >= best) begin
                     best = rank;
                     pick = TASK_W'(pos);
                  end
               end
               pos = (pos + 1) % NUM_TASKS;
            end
            running_q = pick;
            yield_q   = (32'(pick) != start);
         end
      endcase
      d.run_task  = running_q;
      d.yield_req = yield_q;
      return d;
   endfunction

   always @(posedge clock) begin
      decision_type got;
      decision_type want;
      int unsigned  i;
      if (reset) begin
         for (i = 0; i < DEF_NUM_TASKS; i++) begin
            prio_q[i]   = (i == 0) ? '0 : PRIO_W'(1);
            status_q[i] = ST_READY;
            wake_q[i]   = ALL_ONES;
         end
         running_q = '0;
         yield_q   = 1'b0;
         due_decisions.delete();
         fail_tally = 0;
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         // register writes beyond the last task index are dropped
         if (csr_we && csr_index < DEF_NUM_TASKS) begin
            prio_q[csr_index] = csr_wdata;
         end

         // compare a result transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.run_task  = rsp_tdata[TASK_W-1:0];
            got.yield_req = rsp_tdata[TASK_W];
            if (due_decisions.size() == 0) begin
               $display("%0t: result task %0d yield %0b arrived with nothing expected",
                        $time, got.run_task, got.yield_req);
               fail_tally++;
            end else begin
               want = due_decisions.pop_front();
               if (got.run_task !== want.run_task) begin
                  $display("%0t: current_task expected %0d got %0d",
                           $time, want.run_task, got.run_task);
                  fail_tally++;
               end
               if (got.yield_req !== want.yield_req) begin
                  $display("%0t: yield_flag expected %0b got %0b",
                           $time, want.yield_req, got.yield_req);
                  fail_tally++;
               end
            end
         end

         // predict the decision for a request transfer
         if (req_tvalid && req_tready) begin
            due_decisions.push_back(advance_sched(req_tuser, req_tdata[TICK_W-1:0],
                                                  req_tdata[2*TICK_W-1:TICK_W]));
         end

         mismatches  <= fail_tally;
         outstanding <= due_decisions.size();
      end
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import twps_pkg::*;

   localparam int unsigned       WATCHDOG_LIMIT = 2000;
   localparam int unsigned       SEGMENTS       = 8;
   localparam int unsigned       SEG_ITEMS      = 110;
   localparam logic [TICK_W-1:0] ALL_ONES       = '1;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // now_tick, delay_ticks
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;  // cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // current_task, yield_flag
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [PRIO_W-1:0]      csr_wdata  = '0;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned settings_used  = 0;
   int unsigned cmd_count [4];
   logic [TICK_W-1:0] recent_wakes[$];

   task_wake_and_priority_select u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   twps_sched_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   // Stall the result channel at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Abort when no transfer happens on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("task_wake_and_priority_select test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item, with random idle cycles ahead of it, and hold until transfer
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TICK_W-1:0] now_tick,
                            input logic [TICK_W-1:0] dly);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {dly, now_tick};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cmd_count[cmd]++;
      // remember wake ticks so later tick items can hit them
      if (cmd == CMD_DELAY && dly != ALL_ONES) begin
         recent_wakes.push_back(now_tick + dly);
         if (recent_wakes.size() > 8) void'(recent_wakes.pop_front());
      end
   endtask

   // Weighted random command; ticks mostly aim at wake ticks set earlier
   task automatic send_random_item();
      logic [CMD_W-1:0]  cmd;
      logic [TICK_W-1:0] now_tick;
      logic [TICK_W-1:0] dly;
      int unsigned       roll;
      roll     = $urandom_range(99);
      now_tick = $urandom;
      dly      = $urandom;
      if (roll < 30) begin
         cmd = CMD_TICK;
         if (recent_wakes.size() > 0 && $urandom_range(9) < 6) begin
            now_tick = recent_wakes[$urandom_range(recent_wakes.size() - 1)];
         end else if ($urandom_range(9) < 2) begin
            now_tick = ALL_ONES;
         end
      end else if (roll < 55) begin
         cmd = CMD_DELAY;
         case ($urandom_range(4))
            0: begin
               dly = ALL_ONES;
            end
            1, 2: begin
               dly = $urandom_range(100);
            end
            default: ;
         endcase
      end else if (roll < 63) begin
         cmd = CMD_KILL;
      end else begin
         cmd = CMD_SCHED;
      end
      send_item(cmd, now_tick, dly);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Write all priorities, plus the unused indexes above the last task
   task automatic program_prios(input logic [DEF_NUM_TASKS-1:0][PRIO_W-1:0] prio_set);
      int unsigned i;
      for (i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= (i < DEF_NUM_TASKS) ? prio_set[i] : PRIO_W'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   initial begin
      logic [DEF_NUM_TASKS-1:0][PRIO_W-1:0] prio_set;
      int unsigned seg;
      int unsigned n;
      int unsigned i;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed walk with reset priorities: wrap, suspend, kill, revive
      send_item(CMD_SCHED, ALL_ONES, ALL_ONES);
      send_item(CMD_DELAY, 32'hFFFF_FFF0, 32'h0000_0020);
      send_item(CMD_SCHED, '0, '0);
      send_item(CMD_DELAY, 32'h1234_5678, ALL_ONES);
      send_item(CMD_SCHED, '0, ALL_ONES);
      send_item(CMD_KILL, ALL_ONES, '0);
      send_item(CMD_SCHED, '0, '0);
      send_item(CMD_KILL, '0, ALL_ONES);
      send_item(CMD_SCHED, '0, '0);
      send_item(CMD_KILL, '0, '0);
      send_item(CMD_SCHED, ALL_ONES, ALL_ONES);
      send_item(CMD_TICK, '0, ALL_ONES);
      send_item(CMD_TICK, 32'h0000_0010, '0);
      send_item(CMD_SCHED, '0, '0);
      send_item(CMD_TICK, ALL_ONES, '0);
      send_item(CMD_SCHED, '0, '0);
      send_item(CMD_DELAY, '0, '0);
      send_item(CMD_TICK, '0, '0);
      send_item(CMD_DELAY, ALL_ONES, 32'hFFFF_FFFE);
      send_item(CMD_SCHED, '0, '0);
      send_item(CMD_DELAY, ALL_ONES, 32'h0000_0001);
      send_item(CMD_TICK, 32'hFFFF_FFFD, '0);
      send_item(CMD_SCHED, ALL_ONES, ALL_ONES);
      drain_results();

      // Random segments: two priority settings per idling phase
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: prio_set = {DEF_NUM_TASKS{5'd31}};
            1: prio_set = '0;
            2: prio_set = {5'd1, 5'd31, 5'd30, 5'd29, 5'd0};
            3: prio_set = {5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
            default: begin
               for (i = 0; i < DEF_NUM_TASKS; i++) prio_set[i] = PRIO_W'($urandom);
            end
         endcase
         program_prios(prio_set);
         case (seg / 2)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 61;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 61;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase
         for (n = 0; n < SEG_ITEMS; n++) send_random_item();
         // hold the sender off until the block has answered everything
         drain_results();
      end

      $display("covered %0d tick, %0d delay, %0d kill and %0d schedule items",
               cmd_count[CMD_TICK], cmd_count[CMD_DELAY], cmd_count[CMD_KILL],
               cmd_count[CMD_SCHED]);
      $display("under %0d priority settings and four idling phases, %0d mismatches",
               settings_used, mismatches);
      if (mismatches == 0) begin
         $display("task_wake_and_priority_select test passed");
      end else begin
         $display("task_wake_and_priority_select test failed");
      end
      $finish;
   end

endmodule
